// ===== rtl/i64alu_pkg.sv =====
// ----------------------------------------------------------------------------
// i64alu_pkg: shared definitions for the 64-bit wrapping integer ALU
// Holds the opcode codes, data widths and the lane record that moves down
// the cell chain together with each transaction.
// ----------------------------------------------------------------------------
package i64alu_pkg;

    localparam int DATA_W    = 64;
    localparam int HALF_W    = DATA_W / 2;
    localparam int OP_W      = 5;
    localparam int SHIFT_W   = 6;
    // One restoring-division cell per quotient bit.
    localparam int NUM_CELLS = DATA_W;

    localparam logic [OP_W-1:0] OP_ADD  = 5'd0;
    localparam logic [OP_W-1:0] OP_SUB  = 5'd1;
    localparam logic [OP_W-1:0] OP_MUL  = 5'd2;
    localparam logic [OP_W-1:0] OP_DIV  = 5'd3;
    localparam logic [OP_W-1:0] OP_MOD  = 5'd4;
    localparam logic [OP_W-1:0] OP_AND  = 5'd5;
    localparam logic [OP_W-1:0] OP_OR   = 5'd6;
    localparam logic [OP_W-1:0] OP_XOR  = 5'd7;
    localparam logic [OP_W-1:0] OP_SHL  = 5'd8;
    localparam logic [OP_W-1:0] OP_SHR  = 5'd9;
    localparam logic [OP_W-1:0] OP_NEG  = 5'd10;
    localparam logic [OP_W-1:0] OP_LNOT = 5'd11;
    localparam logic [OP_W-1:0] OP_BNOT = 5'd12;
    localparam logic [OP_W-1:0] OP_EQ   = 5'd13;
    localparam logic [OP_W-1:0] OP_NE   = 5'd14;
    localparam logic [OP_W-1:0] OP_LT   = 5'd15;
    localparam logic [OP_W-1:0] OP_LE   = 5'd16;
    localparam logic [OP_W-1:0] OP_GT   = 5'd17;
    localparam logic [OP_W-1:0] OP_GE   = 5'd18;

    // Everything one transaction carries from cell to cell.
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] simple;   // result of the front-cell operations
        logic [DATA_W-1:0] pp_lo;    // low half times low half
        logic [HALF_W-1:0] pp_x1;    // low a times high b, low bits
        logic [HALF_W-1:0] pp_x2;    // high a times low b, low bits
        logic              neg_q;
        logic              neg_r;
        logic              div_zero;
        logic [DATA_W-1:0] rem;      // partial remainder
        logic [DATA_W-1:0] work;     // dividend bits out, quotient bits in
        logic [DATA_W-1:0] divisor;  // magnitude of the divisor
    } lane_t;

endpackage

// ===== rtl/i64alu_prep.sv =====
// ----------------------------------------------------------------------------
// i64alu_prep: front cell of the ALU chain
// Registers a new transaction, computes all combinational results, the
// partial products of the multiply and the operand magnitudes for division.
// ----------------------------------------------------------------------------
module i64alu_prep (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic [i64alu_pkg::OP_W-1:0]         opcode,
    input  logic [i64alu_pkg::DATA_W-1:0]       operand_a,
    input  logic [i64alu_pkg::DATA_W-1:0]       operand_b,
    output logic                                out_valid,
    output i64alu_pkg::lane_t                   out_lane
);

    logic                               valid_reg;
    i64alu_pkg::lane_t                  lane_reg;
    i64alu_pkg::lane_t                  lane_next;
    logic [i64alu_pkg::SHIFT_W-1:0]     shamt;
    logic [i64alu_pkg::DATA_W-1:0]      simple;
    logic                               a_lt_b;
    logic                               b_lt_a;

    assign shamt  = operand_b[i64alu_pkg::SHIFT_W-1:0];
    assign a_lt_b = $signed(operand_a) < $signed(operand_b);
    assign b_lt_a = $signed(operand_b) < $signed(operand_a);

    // Operations computed combinationally in the front cell.
    always_comb
    begin
        case (opcode)
            i64alu_pkg::OP_ADD:  simple = operand_a + operand_b;
            i64alu_pkg::OP_SUB:  simple = operand_a - operand_b;
            i64alu_pkg::OP_AND:  simple = operand_a & operand_b;
            i64alu_pkg::OP_OR:   simple = operand_a | operand_b;
            i64alu_pkg::OP_XOR:  simple = operand_a ^ operand_b;
            i64alu_pkg::OP_SHL:  simple = operand_a << shamt;
            i64alu_pkg::OP_SHR:  simple = $signed(operand_a) >>> shamt;
            i64alu_pkg::OP_NEG:  simple = '0 - operand_a;
            i64alu_pkg::OP_LNOT: simple = 64'(operand_a == '0);
            i64alu_pkg::OP_BNOT: simple = ~operand_a;
            i64alu_pkg::OP_EQ:   simple = 64'(operand_a == operand_b);
            i64alu_pkg::OP_NE:   simple = 64'(operand_a != operand_b);
            i64alu_pkg::OP_LT:   simple = 64'(a_lt_b);
            i64alu_pkg::OP_LE:   simple = 64'(!b_lt_a);
            i64alu_pkg::OP_GT:   simple = 64'(b_lt_a);
            i64alu_pkg::OP_GE:   simple = 64'(!a_lt_b);
            default:             simple = '0;
        endcase
    end

    // Lane contents: partial products and division setup.
    always_comb
    begin
        lane_next.op       = opcode;
        lane_next.simple   = simple;
        lane_next.pp_lo    = operand_a[i64alu_pkg::HALF_W-1:0]
                           * operand_b[i64alu_pkg::HALF_W-1:0];
        lane_next.pp_x1    = operand_a[i64alu_pkg::HALF_W-1:0]
                           * operand_b[i64alu_pkg::DATA_W-1:i64alu_pkg::HALF_W];
        lane_next.pp_x2    = operand_a[i64alu_pkg::DATA_W-1:i64alu_pkg::HALF_W]
                           * operand_b[i64alu_pkg::HALF_W-1:0];
        lane_next.neg_q    = operand_a[i64alu_pkg::DATA_W-1]
                           ^ operand_b[i64alu_pkg::DATA_W-1];
        lane_next.neg_r    = operand_a[i64alu_pkg::DATA_W-1];
        lane_next.div_zero = (operand_b == '0);
        lane_next.rem      = '0;
        lane_next.work     = operand_a[i64alu_pkg::DATA_W-1] ? ('0 - operand_a) : operand_a;
        lane_next.divisor  = operand_b[i64alu_pkg::DATA_W-1] ? ('0 - operand_b) : operand_b;
    end

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (in_valid)
            lane_reg <= lane_next;
    end

    assign out_valid = valid_reg;
    assign out_lane  = lane_reg;

endmodule

// ===== rtl/i64alu_cell.sv =====
// ----------------------------------------------------------------------------
// i64alu_cell: one cell of the division chain
// Produces one quotient bit by restoring division and hands the lane on.
// ----------------------------------------------------------------------------
module i64alu_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  i64alu_pkg::lane_t    in_lane,
    output logic                 out_valid,
    output i64alu_pkg::lane_t    out_lane
);

    logic                               valid_reg;
    i64alu_pkg::lane_t                  lane_reg;
    i64alu_pkg::lane_t                  lane_next;
    logic [i64alu_pkg::DATA_W:0]        shifted;
    logic [i64alu_pkg::DATA_W:0]        diff;

    // Shift in the next dividend bit and try to subtract the divisor.
    assign shifted = {in_lane.rem, in_lane.work[i64alu_pkg::DATA_W-1]};
    assign diff    = shifted - {1'b0, in_lane.divisor};

    always_comb
    begin
        lane_next = in_lane;
        if (!diff[i64alu_pkg::DATA_W])
        begin
            lane_next.rem  = diff[i64alu_pkg::DATA_W-1:0];
            lane_next.work = {in_lane.work[i64alu_pkg::DATA_W-2:0], 1'b1};
        end
        else
        begin
            lane_next.rem  = shifted[i64alu_pkg::DATA_W-1:0];
            lane_next.work = {in_lane.work[i64alu_pkg::DATA_W-2:0], 1'b0};
        end
    end

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (in_valid)
            lane_reg <= lane_next;
    end

    assign out_valid = valid_reg;
    assign out_lane  = lane_reg;

endmodule

// ===== rtl/i64alu_fin.sv =====
// ----------------------------------------------------------------------------
// i64alu_fin: last cell of the ALU chain
// Sums the multiply partial products, applies signs to quotient and
// remainder, selects the result and drives the output register.
// ----------------------------------------------------------------------------
module i64alu_fin (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  i64alu_pkg::lane_t               in_lane,
    output logic                            done,
    output logic [i64alu_pkg::DATA_W-1:0]   result_value
);

    logic                               done_reg;
    logic [i64alu_pkg::DATA_W-1:0]      value_reg;
    logic [i64alu_pkg::DATA_W-1:0]      result_next;
    logic [i64alu_pkg::HALF_W-1:0]      cross_sum;
    logic [i64alu_pkg::DATA_W-1:0]      product;
    logic [i64alu_pkg::DATA_W-1:0]      quotient;
    logic [i64alu_pkg::DATA_W-1:0]      remainder;

    // Low 64 bits of the product.
    assign cross_sum = in_lane.pp_x1 + in_lane.pp_x2;
    assign product   = in_lane.pp_lo + {cross_sum, {i64alu_pkg::HALF_W{1'b0}}};

    // Signed quotient and remainder; a zero divisor gives zero.
    assign quotient  = in_lane.div_zero ? '0
                     : (in_lane.neg_q ? ('0 - in_lane.work) : in_lane.work);
    assign remainder = in_lane.div_zero ? '0
                     : (in_lane.neg_r ? ('0 - in_lane.rem) : in_lane.rem);

    always_comb
    begin
        case (in_lane.op)
            i64alu_pkg::OP_MUL: result_next = product;
            i64alu_pkg::OP_DIV: result_next = quotient;
            i64alu_pkg::OP_MOD: result_next = remainder;
            default:            result_next = in_lane.simple;
        endcase
    end

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= in_valid;
    end

    // Result value.
    always_ff @(posedge clk)
    begin
        if (in_valid)
            value_reg <= result_next;
    end

    assign done         = done_reg;
    assign result_value = value_reg;

endmodule

// ===== rtl/int64_wrapping_alu_core.sv =====
// ----------------------------------------------------------------------------
// int64_wrapping_alu_core: 64-bit wrapping integer ALU
// A front cell, a chain of 64 division cells and a result cell.
//
//   Channel   Ports                                  Handshake
//   command   start, busy, opcode, operand_a/b       start high, busy low
//   result    done, result_value                     done for one cycle
//
// Every transaction passes from start to done through one front cell,
// 64 division cells (one quotient bit each) and one result cell.
// A new transaction is taken every cycle; busy is always low.
// Reset clears the valid flags of all cells; payload is not reset.
// The receiver cannot stall, so results leave in start order.
// ----------------------------------------------------------------------------
module int64_wrapping_alu_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [i64alu_pkg::OP_W-1:0]     opcode,
    input  logic [i64alu_pkg::DATA_W-1:0]   operand_a,
    input  logic [i64alu_pkg::DATA_W-1:0]   operand_b,
    output logic                            done,
    output logic [i64alu_pkg::DATA_W-1:0]   result_value
);

    logic                 chain_valid [0:i64alu_pkg::NUM_CELLS];
    i64alu_pkg::lane_t    chain_lane  [0:i64alu_pkg::NUM_CELLS];
    logic                 accept;

    // The pipeline takes a transaction every cycle.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Front cell.
    i64alu_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .opcode    (opcode),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .out_valid (chain_valid[0]),
        .out_lane  (chain_lane[0])
    );

    // Division cells.
    genvar gi;
    generate
        for (gi = 0; gi < i64alu_pkg::NUM_CELLS; gi++)
        begin : g_cell
            i64alu_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (chain_valid[gi]),
                .in_lane   (chain_lane[gi]),
                .out_valid (chain_valid[gi+1]),
                .out_lane  (chain_lane[gi+1])
            );
        end
    endgenerate

    // Result cell.
    i64alu_fin u_fin (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (chain_valid[i64alu_pkg::NUM_CELLS]),
        .in_lane      (chain_lane[i64alu_pkg::NUM_CELLS]),
        .done         (done),
        .result_value (result_value)
    );

    // An accepted transaction enters the front cell.
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> chain_valid[0])
        else $error("accepted transaction did not enter the chain");

    // The end of the chain always produces a result strobe.
    a_chain_done: assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[i64alu_pkg::NUM_CELLS] |=> done)
        else $error("transaction at the end of the chain gave no result");

    // Comparisons and logical not give 0 or 1.
    a_bool_result: assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[i64alu_pkg::NUM_CELLS]
        && (chain_lane[i64alu_pkg::NUM_CELLS].op == i64alu_pkg::OP_LNOT
            || chain_lane[i64alu_pkg::NUM_CELLS].op == i64alu_pkg::OP_EQ
            || chain_lane[i64alu_pkg::NUM_CELLS].op == i64alu_pkg::OP_NE
            || chain_lane[i64alu_pkg::NUM_CELLS].op == i64alu_pkg::OP_LT
            || chain_lane[i64alu_pkg::NUM_CELLS].op == i64alu_pkg::OP_LE
            || chain_lane[i64alu_pkg::NUM_CELLS].op == i64alu_pkg::OP_GT
            || chain_lane[i64alu_pkg::NUM_CELLS].op == i64alu_pkg::OP_GE)
        |=> (result_value[i64alu_pkg::DATA_W-1:1] == '0))
        else $error("boolean operation gave a value other than 0 or 1");

endmodule

// ===== dv/int64_wrapping_alu_core_tb.sv =====
// ----------------------------------------------------------------------------
// int64_wrapping_alu_core_tb: self-checking bench for the 64-bit integer ALU
// Sends directed corner cases and random operations through the command
// port, predicts each result in the bench and compares every done pulse
// with the oldest prediction in order.
// ----------------------------------------------------------------------------
module int64_wrapping_alu_core_tb;

    typedef logic [i64alu_pkg::DATA_W-1:0] word_t;
    typedef logic [i64alu_pkg::OP_W-1:0]   op_t;

    localparam int    LATENCY     = 66;
    localparam int    CYCLE_LIMIT = 200000;
    localparam word_t MIN_VAL     = 64'h8000_0000_0000_0000;
    localparam word_t MAX_VAL     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam word_t ONES        = 64'hFFFF_FFFF_FFFF_FFFF;
    // Highest opcode, which has no meaning.
    localparam op_t   OP_UNUSED   = 5'd31;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    op_t     opcode = '0;
    word_t   operand_a = '0;
    word_t   operand_b = '0;
    logic    done;
    word_t   result_value;

    word_t   expected_results[$];
    int      error_count = 0;
    int      sent_count = 0;
    int      checked_count = 0;
    int      cycle_count = 0;
    int      burst_left = 0;

    always #1 clk = ~clk;

    int64_wrapping_alu_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .operand_a    (operand_a),
        .operand_b    (operand_b),
        .done         (done),
        .result_value (result_value)
    );

    // Signed less-than on raw bit patterns.
    function automatic bit signed_less(word_t a, word_t b);
        return $signed(a) < $signed(b);
    endfunction

    // Expected ALU output for one operation.
    function automatic word_t alu_result(op_t op, word_t a, word_t b);
        word_t mag_a;
        word_t mag_b;
        word_t quo;
        word_t rem;
        mag_a = a[i64alu_pkg::DATA_W-1] ? -a : a;
        mag_b = b[i64alu_pkg::DATA_W-1] ? -b : b;
        quo = (mag_b == 0) ? '0 : mag_a / mag_b;
        rem = (mag_b == 0) ? '0 : mag_a % mag_b;
        case (op)
            i64alu_pkg::OP_ADD:  return a + b;
            i64alu_pkg::OP_SUB:  return a - b;
            i64alu_pkg::OP_MUL:  return a * b;
            i64alu_pkg::OP_DIV:
            begin
                if (b == 0) return '0;
                if (a == MIN_VAL && b == ONES) return MIN_VAL;
                return (a[i64alu_pkg::DATA_W-1] != b[i64alu_pkg::DATA_W-1]) ? -quo : quo;
            end
            i64alu_pkg::OP_MOD:
            begin
                if (b == 0) return '0;
                if (a == MIN_VAL && b == ONES) return '0;
                return a[i64alu_pkg::DATA_W-1] ? -rem : rem;
            end
            i64alu_pkg::OP_AND:  return a & b;
            i64alu_pkg::OP_OR:   return a | b;
            i64alu_pkg::OP_XOR:  return a ^ b;
            i64alu_pkg::OP_SHL:  return a << b[i64alu_pkg::SHIFT_W-1:0];
            i64alu_pkg::OP_SHR:  return $signed(a) >>> b[i64alu_pkg::SHIFT_W-1:0];
            i64alu_pkg::OP_NEG:  return -a;
            i64alu_pkg::OP_LNOT: return (a == 0) ? 64'd1 : 64'd0;
            i64alu_pkg::OP_BNOT: return ~a;
            i64alu_pkg::OP_EQ:   return (a == b) ? 64'd1 : 64'd0;
            i64alu_pkg::OP_NE:   return (a != b) ? 64'd1 : 64'd0;
            i64alu_pkg::OP_LT:   return signed_less(a, b) ? 64'd1 : 64'd0;
            i64alu_pkg::OP_LE:   return signed_less(b, a) ? 64'd0 : 64'd1;
            i64alu_pkg::OP_GT:   return signed_less(b, a) ? 64'd1 : 64'd0;
            i64alu_pkg::OP_GE:   return signed_less(a, b) ? 64'd0 : 64'd1;
            default:             return '0;
        endcase
    endfunction

    // Random operand that often lands on an edge value.
    function automatic word_t pick_operand();
        case ($urandom_range(0, 9))
            0: return MIN_VAL;
            1: return MAX_VAL;
            2: return ONES;
            3: return '0;
            4: return 64'(signed'($urandom_range(0, 20)) - 10);
            5: return {32'h0, $urandom()};
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // Send one transaction; the sender works in bursts with random gaps.
    task automatic send_op(op_t op, word_t a, word_t b);
        if (burst_left == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(0, 4)) @(negedge clk);
            burst_left = $urandom_range(1, 30);
        end
        start     <= 1'b1;
        opcode    <= op;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (busy) @(posedge clk);
        expected_results.insert(expected_results.size(), alu_result(op, a, b));
        sent_count++;
        burst_left--;
        @(negedge clk);
    endtask

    // Lower start and wait until every expected result has arrived.
    task automatic drain();
        start <= 1'b0;
        burst_left = 0;
        while (expected_results.size() != 0) @(negedge clk);
    endtask

    // Directed corners: every opcode and each special case.
    task automatic test_directed();
        send_op(i64alu_pkg::OP_ADD, MAX_VAL, 64'd1);
        send_op(i64alu_pkg::OP_SUB, MIN_VAL, 64'd1);
        send_op(i64alu_pkg::OP_MUL, MAX_VAL, MAX_VAL);
        send_op(i64alu_pkg::OP_DIV, 64'd7, '0);
        send_op(i64alu_pkg::OP_MOD, 64'd7, '0);
        send_op(i64alu_pkg::OP_DIV, MIN_VAL, ONES);
        send_op(i64alu_pkg::OP_MOD, MIN_VAL, ONES);
        send_op(i64alu_pkg::OP_DIV, -64'd7, 64'd2);
        send_op(i64alu_pkg::OP_MOD, -64'd7, 64'd2);
        send_op(i64alu_pkg::OP_AND, ONES, MAX_VAL);
        send_op(i64alu_pkg::OP_OR, MIN_VAL, 64'd1);
        send_op(i64alu_pkg::OP_XOR, ONES, MIN_VAL);
        send_op(i64alu_pkg::OP_SHL, 64'd1, 64'd67);
        send_op(i64alu_pkg::OP_SHR, MIN_VAL, 64'd63);
        send_op(i64alu_pkg::OP_SHR, MAX_VAL, ONES);
        send_op(i64alu_pkg::OP_NEG, MIN_VAL, ONES);
        send_op(i64alu_pkg::OP_LNOT, '0, ONES);
        send_op(i64alu_pkg::OP_LNOT, MIN_VAL, '0);
        send_op(i64alu_pkg::OP_BNOT, '0, '0);
        send_op(i64alu_pkg::OP_EQ, ONES, ONES);
        send_op(i64alu_pkg::OP_NE, ONES, ONES);
        send_op(i64alu_pkg::OP_LT, MIN_VAL, MAX_VAL);
        send_op(i64alu_pkg::OP_LE, MAX_VAL, MAX_VAL);
        send_op(i64alu_pkg::OP_GT, MIN_VAL, ONES);
        send_op(i64alu_pkg::OP_GE, ONES, '0);
        send_op(OP_UNUSED, ONES, ONES);
    endtask

    // Random operations, including the undefined opcodes, with a full pause halfway.
    task automatic test_random(int count);
        op_t op;
        for (int i = 0; i < count; i++)
        begin
            op = ($urandom_range(0, 15) == 0) ? op_t'($urandom_range(19, 31))
                                              : op_t'($urandom_range(0, 18));
            send_op(op, pick_operand(), pick_operand());
            if (i == count / 2) drain();
        end
    endtask

    // Check each done pulse against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result_value: unexpected transaction, actual %h", result_value);
                error_count++;
            end
            else
            begin
                if (result_value !== expected_results[0])
                begin
                    $error("result_value: expected %h, actual %h",
                           expected_results[0], result_value);
                    error_count++;
                end
                void'(expected_results.pop_front());
                checked_count++;
            end
        end
    end

    // Guard against a hang.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_random(900);
        drain();
        repeat (LATENCY + 10) @(negedge clk);
        if (expected_results.size() != 0) error_count++;
        $display("Covered %0d transactions over all opcodes, %0d results checked.",
                 sent_count, checked_count);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/i64alu_pkg.sv
rtl/i64alu_prep.sv
rtl/i64alu_cell.sv
rtl/i64alu_fin.sv
rtl/int64_wrapping_alu_core.sv
dv/int64_wrapping_alu_core_tb.sv
